// File: src/priority_fetch_queue_with_dedup_macros.svh
// assertion macros shared by the checker
`ifndef PRIORITY_FETCH_QUEUE_WITH_DEDUP_MACROS_SVH
`define PRIORITY_FETCH_QUEUE_WITH_DEDUP_MACROS_SVH

// property that must hold at every clock edge outside reset
`define PFQD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked from one edge to the next
`define PFQD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/pfqd_pkg.sv
`default_nettype none
package pfqd_pkg;

  // chunk space and ring geometry
  localparam int NUM_CHUNKS = 1024;
  localparam int RING_CAP   = NUM_CHUNKS + 1;
  localparam int RING_AW    = $clog2(RING_CAP);
  localparam int LEN_W      = $clog2(RING_CAP + 1);
  localparam int SUM_W      = LEN_W + 1;
  localparam int IDX_W      = $clog2(NUM_CHUNKS);

  // fixed field widths
  localparam int CHUNK_W    = 10;
  localparam int CNT_W      = 11;
  localparam int OP_W       = 3;
  localparam int STATUS_W   = 3;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;

  // request opcodes
  typedef enum logic [OP_W-1:0] {
    OP_DEMAND_ENQ    = 3'd0,
    OP_WALK_START    = 3'd1,
    OP_CANDIDATE     = 3'd2,
    OP_DISPATCH      = 3'd3,
    OP_PREFETCH_DONE = 3'd4
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED = 3'd0,
    ST_SKIPPED  = 3'd1,
    ST_WALK_END = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_NO_WALK  = 3'd5
  } status_t;

  // dispatch kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_NONE     = 2'd0,
    KIND_DEMAND   = 2'd1,
    KIND_PREFETCH = 2'd2
  } kind_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PREFETCH_DEPTH = 1'd0,
    REG_CHUNK_COUNT    = 1'd1
  } cfg_reg_t;

  // control sequencer states
  typedef enum logic [1:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_EXEC
  } fsm_t;

  // captured request
  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [CHUNK_W-1:0] idx;
    logic               cand_valid;
    logic               absent;
    logic               backoff;
  } req_t;

  // result payload, last field in the lowest bits
  typedef struct packed {
    logic [CNT_W-1:0]   outstanding;
    logic [CNT_W-1:0]   walk_rem;
    logic [CHUNK_W-1:0] dindex;
    status_t            status;
  } result_t;

  // ring slot head + offset modulo the ring capacity
  function automatic logic [RING_AW-1:0] ring_add(input logic [RING_AW-1:0] head,
                                                  input logic [LEN_W-1:0]   off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(head) + SUM_W'(off);
    if (s >= SUM_W'(RING_CAP)) begin
      s = s - SUM_W'(RING_CAP);
    end
    return s[RING_AW-1:0];
  endfunction

endpackage
`default_nettype wire

// File: src/pfqd_ram.sv
`default_nettype none
module pfqd_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 1,
  parameter int AW    = 10
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: src/priority_fetch_queue_with_dedup.sv
// a request is captured together with the ring and tracked-bitmap reads; its result is
//   registered on leaving the execute state and then shows on out_tvalid
// a new request is taken only after the last one is through, as the ring and tracked-bitmap
//   memories are read and then written back; a waiting result stalls the write-back
// reset: control state clears at once, then a pass over every chunk zeroes the tracked bitmap
//   with in_tready low; configuration writes are taken throughout
`default_nettype none
module priority_fetch_queue_with_dedup (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // in_tdata: chunk_index[9:0], candidate_valid[10], absent[11], in_backoff[12]
  input  wire logic [pfqd_pkg::IN_DATA_W-1:0]      in_tdata,
  // in_tuser: opcode[2:0]
  input  wire logic [pfqd_pkg::OP_W-1:0]           in_tuser,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // out_tdata: status[2:0], dispatch_index[12:3], walk_remaining[23:13],
  //   outstanding_count[34:24]
  output logic [pfqd_pkg::OUT_DATA_W-1:0]          out_tdata,
  // out_tuser: dispatch_kind[1:0]
  output logic [pfqd_pkg::KIND_W-1:0]              out_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [pfqd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [pfqd_pkg::CNT_W-1:0]          cfg_data
);

  localparam int CW = pfqd_pkg::CHUNK_W;
  localparam int NW = pfqd_pkg::CNT_W;
  localparam int AW = pfqd_pkg::RING_AW;
  localparam int LW = pfqd_pkg::LEN_W;
  localparam int IW = pfqd_pkg::IDX_W;

  pfqd_pkg::fsm_t    fsm_r, fsm_nxt;
  logic [IW-1:0]     clr_cnt_r, clr_cnt_nxt;
  pfqd_pkg::req_t    req_r;
  logic [AW-1:0]     demand_head_r, demand_head_nxt;
  logic [LW-1:0]     demand_len_r, demand_len_nxt;
  logic [AW-1:0]     spec_head_r, spec_head_nxt;
  logic [LW-1:0]     spec_len_r, spec_len_nxt;
  logic [NW-1:0]     outstanding_r, outstanding_nxt;
  logic [NW-1:0]     walk_budget_r, walk_budget_nxt;
  logic [CW-1:0]     walk_origin_r, walk_origin_nxt;
  logic [NW-1:0]     prefetch_depth_r;
  logic [NW-1:0]     chunk_count_r;
  logic              out_valid_r, out_valid_nxt;
  pfqd_pkg::result_t out_data_r, out_data_nxt;
  pfqd_pkg::kind_t   out_kind_r, out_kind_nxt;

  logic              in_fire;
  logic              finish;
  logic [NW-1:0]     eff_count;

  // memory ports
  logic              dm_we, sp_we, tr_we;
  logic [AW-1:0]     dm_waddr, sp_waddr;
  logic [IW-1:0]     tr_waddr;
  logic              tr_wdata;
  logic [CW-1:0]     dm_rdata, sp_rdata;
  logic              tr_rdata;

  assign in_tready = (fsm_r == pfqd_pkg::FSM_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign cfg_ready = 1'b1;
  assign finish    = (fsm_r == pfqd_pkg::FSM_EXEC) && (!out_valid_r || out_tready);
  assign eff_count = (chunk_count_r > NW'(pfqd_pkg::NUM_CHUNKS)) ?
                     NW'(pfqd_pkg::NUM_CHUNKS) : chunk_count_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = pfqd_pkg::OUT_DATA_W'(out_data_r);
  assign out_tuser  = out_kind_r;

  // demand ring, read at the head when a request is taken
  pfqd_ram #(.DEPTH(pfqd_pkg::RING_CAP), .WIDTH(CW), .AW(AW)) u_demand_ram (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (req_r.idx),
    .re    (in_fire),
    .raddr (demand_head_r),
    .rdata (dm_rdata)
  );

  // speculative ring
  pfqd_ram #(.DEPTH(pfqd_pkg::RING_CAP), .WIDTH(CW), .AW(AW)) u_spec_ram (
    .clk   (clk),
    .we    (sp_we),
    .waddr (sp_waddr),
    .wdata (req_r.idx),
    .re    (in_fire),
    .raddr (spec_head_r),
    .rdata (sp_rdata)
  );

  // tracked bitmap, one bit per chunk
  pfqd_ram #(.DEPTH(pfqd_pkg::NUM_CHUNKS), .WIDTH(1), .AW(IW)) u_tracked_ram (
    .clk   (clk),
    .we    (tr_we),
    .waddr (tr_waddr),
    .wdata (tr_wdata),
    .re    (in_fire),
    .raddr (in_tdata[IW-1:0]),
    .rdata (tr_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefetch_depth_r <= NW'(1);
      chunk_count_r    <= NW'(pfqd_pkg::NUM_CHUNKS);
    end else if (cfg_valid && cfg_ready) begin
      unique case (pfqd_pkg::cfg_reg_t'(cfg_index))
        pfqd_pkg::REG_PREFETCH_DEPTH: prefetch_depth_r <= cfg_data;
        pfqd_pkg::REG_CHUNK_COUNT:    chunk_count_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r.opcode     <= in_tuser;
      req_r.idx        <= in_tdata[CW-1:0];
      req_r.cand_valid <= in_tdata[CW];
      req_r.absent     <= in_tdata[CW+1];
      req_r.backoff    <= in_tdata[CW+2];
    end
  end

  // sequencer and read-modify-write of the queue state
  always_comb begin
    fsm_nxt         = fsm_r;
    clr_cnt_nxt     = clr_cnt_r;
    demand_head_nxt = demand_head_r;
    demand_len_nxt  = demand_len_r;
    spec_head_nxt   = spec_head_r;
    spec_len_nxt    = spec_len_r;
    outstanding_nxt = outstanding_r;
    walk_budget_nxt = walk_budget_r;
    walk_origin_nxt = walk_origin_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_data_nxt    = out_data_r;
    out_kind_nxt    = out_kind_r;
    dm_we           = 1'b0;
    dm_waddr        = pfqd_pkg::ring_add(demand_head_r, demand_len_r);
    sp_we           = 1'b0;
    sp_waddr        = pfqd_pkg::ring_add(spec_head_r, spec_len_r);
    tr_we           = 1'b0;
    tr_waddr        = req_r.idx[IW-1:0];
    tr_wdata        = 1'b0;

    unique case (fsm_r)
      // zero the tracked bitmap one entry a cycle
      pfqd_pkg::FSM_CLEAR: begin
        tr_we       = 1'b1;
        tr_waddr    = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + IW'(1);
        if (clr_cnt_r == IW'(pfqd_pkg::NUM_CHUNKS - 1)) begin
          fsm_nxt = pfqd_pkg::FSM_IDLE;
        end
      end

      pfqd_pkg::FSM_IDLE: begin
        if (in_fire) begin
          fsm_nxt = pfqd_pkg::FSM_EXEC;
        end
      end

      pfqd_pkg::FSM_EXEC: begin
        if (finish) begin
          fsm_nxt             = pfqd_pkg::FSM_IDLE;
          out_valid_nxt       = 1'b1;
          out_kind_nxt        = pfqd_pkg::KIND_NONE;
          out_data_nxt.dindex = '0;
          out_data_nxt.status = pfqd_pkg::ST_SKIPPED;

          unique case (req_r.opcode)
            // demand enqueue
            pfqd_pkg::OP_DEMAND_ENQ: begin
              if (demand_len_r >= LW'(pfqd_pkg::RING_CAP)) begin
                out_data_nxt.status = pfqd_pkg::ST_OVERFLOW;
              end else begin
                dm_we               = 1'b1;
                demand_len_nxt      = demand_len_r + LW'(1);
                out_data_nxt.status = pfqd_pkg::ST_ACCEPTED;
              end
            end

            // walk start: budget is depth minus outstanding, floored at zero
            pfqd_pkg::OP_WALK_START: begin
              walk_budget_nxt = (prefetch_depth_r > outstanding_r) ?
                                prefetch_depth_r - outstanding_r : '0;
              walk_origin_nxt = req_r.idx;
              out_data_nxt.status = (walk_budget_nxt != '0) ?
                                    pfqd_pkg::ST_ACCEPTED : pfqd_pkg::ST_WALK_END;
            end

            // prefetch candidate
            pfqd_pkg::OP_CANDIDATE: begin
              if (walk_budget_r == '0) begin
                out_data_nxt.status = pfqd_pkg::ST_NO_WALK;
              end else if (!req_r.cand_valid || (NW'(req_r.idx) >= eff_count) ||
                           (req_r.idx == walk_origin_r)) begin
                walk_budget_nxt     = '0;
                out_data_nxt.status = pfqd_pkg::ST_WALK_END;
              end else begin
                walk_budget_nxt = walk_budget_r - NW'(1);
                if (!tr_rdata && req_r.absent && !req_r.backoff &&
                    (spec_len_r < LW'(pfqd_pkg::RING_CAP))) begin
                  tr_we               = 1'b1;
                  tr_wdata            = 1'b1;
                  sp_we               = 1'b1;
                  spec_len_nxt        = spec_len_r + LW'(1);
                  outstanding_nxt     = outstanding_r + NW'(1);
                  out_data_nxt.status = pfqd_pkg::ST_ACCEPTED;
                end
              end
            end

            // dispatch, demand ring first
            pfqd_pkg::OP_DISPATCH: begin
              if (demand_len_r != '0) begin
                out_data_nxt.dindex = dm_rdata;
                demand_head_nxt     = pfqd_pkg::ring_add(demand_head_r, LW'(1));
                demand_len_nxt      = demand_len_r - LW'(1);
                out_kind_nxt        = pfqd_pkg::KIND_DEMAND;
                out_data_nxt.status = pfqd_pkg::ST_ACCEPTED;
              end else if (spec_len_r != '0) begin
                out_data_nxt.dindex = sp_rdata;
                spec_head_nxt       = pfqd_pkg::ring_add(spec_head_r, LW'(1));
                spec_len_nxt        = spec_len_r - LW'(1);
                out_kind_nxt        = pfqd_pkg::KIND_PREFETCH;
                out_data_nxt.status = pfqd_pkg::ST_ACCEPTED;
              end else begin
                out_data_nxt.status = pfqd_pkg::ST_EMPTY;
              end
            end

            // prefetch completion releases a tracked chunk
            pfqd_pkg::OP_PREFETCH_DONE: begin
              if ((NW'(req_r.idx) < NW'(pfqd_pkg::NUM_CHUNKS)) && tr_rdata &&
                  (outstanding_r != '0)) begin
                tr_we               = 1'b1;
                tr_wdata            = 1'b0;
                outstanding_nxt     = outstanding_r - NW'(1);
                out_data_nxt.status = pfqd_pkg::ST_ACCEPTED;
              end
            end

            default: ;
          endcase

          out_data_nxt.walk_rem    = walk_budget_nxt;
          out_data_nxt.outstanding = outstanding_nxt;
        end
      end

      default: fsm_nxt = pfqd_pkg::FSM_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r         <= pfqd_pkg::FSM_CLEAR;
      clr_cnt_r     <= '0;
      demand_head_r <= '0;
      demand_len_r  <= '0;
      spec_head_r   <= '0;
      spec_len_r    <= '0;
      outstanding_r <= '0;
      walk_budget_r <= '0;
      walk_origin_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      fsm_r         <= fsm_nxt;
      clr_cnt_r     <= clr_cnt_nxt;
      demand_head_r <= demand_head_nxt;
      demand_len_r  <= demand_len_nxt;
      spec_head_r   <= spec_head_nxt;
      spec_len_r    <= spec_len_nxt;
      outstanding_r <= outstanding_nxt;
      walk_budget_r <= walk_budget_nxt;
      walk_origin_r <= walk_origin_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_kind_r <= out_kind_nxt;
  end

endmodule
`default_nettype wire

// File: src/pfqd_checker.sv
`default_nettype none
`include "priority_fetch_queue_with_dedup_macros.svh"
module pfqd_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_tvalid,
  input wire logic                                in_tready,
  input wire logic [pfqd_pkg::OUT_DATA_W-1:0]     out_tdata,
  input wire logic [pfqd_pkg::KIND_W-1:0]         out_tuser,
  input wire logic                                out_tvalid,
  input wire logic                                out_tready
);

  // a stalled result keeps its payload
  `PFQD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // one request at a time: ready drops right after a request is taken
  `PFQD_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "request taken while another is in work")

  // no dispatch means a zero index
  `PFQD_ASSERT(a_idle_index, !out_tvalid || (out_tuser != pfqd_pkg::KIND_NONE) || (out_tdata[12:3] == '0), "index set without dispatch")

  // a dispatch always reports accepted
  `PFQD_ASSERT(a_dispatch_status, !out_tvalid || (out_tuser == pfqd_pkg::KIND_NONE) || (out_tdata[2:0] == pfqd_pkg::ST_ACCEPTED), "dispatch without accepted status")

endmodule

bind priority_fetch_queue_with_dedup pfqd_checker u_pfqd_checker (.*);
`default_nettype wire
